// ----- src/block_average_level_meter_assert.svh -----
// Assertion macros for the file that checks the level meter.
`ifndef BLOCK_AVERAGE_LEVEL_METER_ASSERT_SVH
`define BLOCK_AVERAGE_LEVEL_METER_ASSERT_SVH

// The antecedent holds in a cycle, so the consequent holds in the same cycle.
`define BALM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent holds in a cycle, so the consequent holds in the next cycle.
`define BALM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The expression holds at every clock edge outside reset.
`define BALM_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

// ----- src/balm_pkg.sv -----
`default_nettype none

package balm_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int BLEN_W     = 11;
    localparam int GAIN_W     = 20;
    localparam int OFFSET_W   = 18;
    localparam int MEAN_OUT_W = 24;
    localparam int LEVEL_W    = 18;
    localparam int GAIN_FRAC  = 20;
    localparam int FRAC_BITS  = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DB_GAIN      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DB_OFFSET    = 2'd2;

    localparam int BLEN_RESET   = 500;
    localparam int GAIN_RESET   = 9961;
    localparam int OFFSET_RESET = -29330;

    localparam int LEVEL_MAX = 131071;
    localparam int LEVEL_MIN = -131072;

    localparam int AVG_DEPTH_DEFAULT   = 4;
    localparam int SAMPLE_BITS_DEFAULT = 16;
    localparam int MAX_BLOCK_DEFAULT   = 1024;

    typedef struct packed {
        logic sample_take;
        logic mean_start;
        logic mean_load;
        logic hist_update;
        logic avg_start;
        logic mov_load;
        logic mul_lo;
        logic mul_hi;
        logic prod_sum;
        logic result_load;
    } balm_cmd_t;

    typedef struct packed {
        logic block_close;
        logic div_busy;
        logic avg_shift;
    } balm_stat_t;

endpackage

`default_nettype wire

// ----- src/balm_if.sv -----
`default_nettype none

interface balm_sample_if
    import balm_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface balm_result_if
    import balm_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [MEAN_OUT_W-1:0] block_mean;
    logic [SAMPLE_W-1:0]   block_max;
    logic [SAMPLE_W-1:0]   block_min;
    logic [MEAN_OUT_W-1:0] moving_average;
    logic [LEVEL_W-1:0]    level_db;

    modport source (output valid, output block_mean, output block_max, output block_min,
                    output moving_average, output level_db, input ready);
    modport sink (input valid, input block_mean, input block_max, input block_min,
                  input moving_average, input level_db, output ready);
endinterface

interface balm_cfg_if
    import balm_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/balm_divider.sv -----
`default_nettype none

module balm_divider
    import balm_pkg::*;
#(
    parameter int DIVD_W = 36,
    parameter int DIVS_W = 11
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DIVS_W-1:0] divisor,
    output logic              busy,
    output logic [DIVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [DIVD_W-1:0] quo_next;
    logic [DIVS_W-1:0] rem_reg;
    logic [DIVS_W-1:0] rem_next;
    logic [DIVS_W-1:0] dvs_reg;
    logic [DIVS_W:0]   rem_shift;
    logic              fits;

    // One quotient bit per cycle, most significant first.
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIVD_W-1]};
        fits      = rem_shift >= {1'b0, dvs_reg};
        rem_next  = fits ? DIVS_W'(rem_shift - {1'b0, dvs_reg}) : rem_shift[DIVS_W-1:0];
        quo_next  = {quo_reg[DIVD_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DIVD_W);
        end
        else if (busy_reg)
        begin
            busy_reg <= (cnt_reg != CNT_W'(1));
            cnt_reg  <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- src/balm_datapath.sv -----
`default_nettype none

module balm_datapath
    import balm_pkg::*;
#(
    parameter int AVG_DEPTH   = AVG_DEPTH_DEFAULT,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
    parameter int MAX_BLOCK   = MAX_BLOCK_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  balm_cmd_t             cmd,
    output balm_stat_t            stat,
    input  logic [SAMPLE_W-1:0]   sample,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [MEAN_OUT_W-1:0] block_mean,
    output logic [SAMPLE_W-1:0]   block_max,
    output logic [SAMPLE_W-1:0]   block_min,
    output logic [MEAN_OUT_W-1:0] moving_average,
    output logic [LEVEL_W-1:0]    level_db
);

    localparam int LEN_W   = $clog2(MAX_BLOCK + 1);
    localparam int SUM_W   = SAMPLE_BITS + $clog2(MAX_BLOCK);
    localparam int MEAN_W  = SUM_W + FRAC_BITS;
    localparam int HSUM_W  = MEAN_W + $clog2(AVG_DEPTH);
    localparam int DEPTH_W = $clog2(AVG_DEPTH + 1);
    localparam int DIVS_W  = (LEN_W > DEPTH_W) ? LEN_W : DEPTH_W;
    localparam int PTR_W   = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int LO_W    = (MEAN_W + 1) / 2;
    localparam int HI_W    = MEAN_W - LO_W;
    localparam int PROD_W  = GAIN_W + MEAN_W;
    localparam int SCL_W   = PROD_W - GAIN_FRAC;
    localparam int LVL_W   = MEAN_W + 2;
    localparam int AVG_SH  = $clog2(AVG_DEPTH);

    localparam bit AVG_POW2 = ((AVG_DEPTH & (AVG_DEPTH - 1)) == 0);

    localparam logic signed [LVL_W-1:0] LVL_HI = LVL_W'(LEVEL_MAX);
    localparam logic signed [LVL_W-1:0] LVL_LO = LVL_W'(LEVEL_MIN);

    logic [BLEN_W-1:0]      blen_reg;
    logic [GAIN_W-1:0]      gain_reg;
    logic [OFFSET_W-1:0]    offset_reg;

    logic [SUM_W-1:0]       sum_reg;
    logic [LEN_W-1:0]       count_reg;
    logic [SAMPLE_BITS-1:0] max_reg;
    logic [SAMPLE_BITS-1:0] min_reg;
    logic [MEAN_W-1:0]      hist_reg [AVG_DEPTH];
    logic [HSUM_W-1:0]      hsum_reg;
    logic [PTR_W-1:0]       ptr_reg;
    logic [PTR_W-1:0]       ptr_next;

    logic [MEAN_W-1:0]        mean_reg;
    logic [MEAN_W-1:0]        mov_reg;
    logic [GAIN_W+LO_W-1:0]   plo_reg;
    logic [GAIN_W+HI_W-1:0]   phi_reg;
    logic [SCL_W-1:0]         scaled_reg;
    logic [PROD_W-1:0]        prod;

    logic [MEAN_OUT_W-1:0]  res_mean_reg;
    logic [SAMPLE_W-1:0]    res_max_reg;
    logic [SAMPLE_W-1:0]    res_min_reg;
    logic [MEAN_OUT_W-1:0]  res_mov_reg;
    logic [LEVEL_W-1:0]     res_level_reg;

    logic [SAMPLE_BITS-1:0] smp;
    logic [31:0]            blen_wide;
    logic [LEN_W-1:0]       eff_len;
    logic [LEN_W-1:0]       count_inc;

    logic                   div_start;
    logic [HSUM_W-1:0]      div_dividend;
    logic [DIVS_W-1:0]      div_divisor;
    logic                   div_busy;
    logic [HSUM_W-1:0]      div_quotient;
    logic [HSUM_W-1:0]      hsum_shift;

    logic signed [LVL_W-1:0] lvl_sum;
    logic [LEVEL_W-1:0]      level_sat;

    // Sample bits above the configured sample width are dropped.
    assign smp = SAMPLE_BITS'(32'(sample));

    // A zero length closes every sample; lengths above the maximum saturate.
    assign blen_wide = 32'(blen_reg);
    assign eff_len   = (blen_reg == '0) ? LEN_W'(1) :
                       (blen_wide > 32'(MAX_BLOCK)) ? LEN_W'(MAX_BLOCK) : LEN_W'(blen_wide);
    assign count_inc = count_reg + LEN_W'(1);

    assign stat.block_close = count_inc >= eff_len;
    assign stat.div_busy    = div_busy;
    assign stat.avg_shift   = AVG_POW2;

    // A power-of-two history depth turns the moving average into a shift.
    assign hsum_shift = hsum_reg >> AVG_SH;

    assign div_start    = cmd.mean_start | cmd.avg_start;
    assign div_dividend = cmd.avg_start ? hsum_reg
                                        : HSUM_W'({sum_reg, {FRAC_BITS{1'b0}}});
    assign div_divisor  = cmd.avg_start ? DIVS_W'(AVG_DEPTH) : DIVS_W'(eff_len);

    balm_divider #(
        .DIVD_W (HSUM_W),
        .DIVS_W (DIVS_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    assign ptr_next = (ptr_reg == PTR_W'(AVG_DEPTH - 1)) ? '0 : ptr_reg + PTR_W'(1);

    assign prod = PROD_W'(plo_reg) + (PROD_W'(phi_reg) << LO_W);

    always_comb
    begin
        lvl_sum = $signed({2'b00, scaled_reg})
                + $signed({{(LVL_W - OFFSET_W){offset_reg[OFFSET_W-1]}}, offset_reg});
        if (lvl_sum > LVL_HI)
        begin
            level_sat = LEVEL_W'(LVL_HI);
        end
        else if (lvl_sum < LVL_LO)
        begin
            level_sat = LEVEL_W'(LVL_LO);
        end
        else
        begin
            level_sat = LEVEL_W'(lvl_sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blen_reg   <= BLEN_W'(BLEN_RESET);
            gain_reg   <= GAIN_W'(GAIN_RESET);
            offset_reg <= OFFSET_W'(OFFSET_RESET);
            sum_reg    <= '0;
            count_reg  <= '0;
            max_reg    <= '0;
            min_reg    <= '1;
            for (int i = 0; i < AVG_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
            hsum_reg   <= '0;
            ptr_reg    <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_BLOCK_LENGTH: blen_reg   <= cfg_data[BLEN_W-1:0];
                    CFG_DB_GAIN:      gain_reg   <= cfg_data[GAIN_W-1:0];
                    CFG_DB_OFFSET:    offset_reg <= cfg_data[OFFSET_W-1:0];
                    default:          ;
                endcase
            end
            if (cmd.sample_take)
            begin
                sum_reg   <= sum_reg + SUM_W'(smp);
                count_reg <= count_inc;
                if (smp > max_reg)
                begin
                    max_reg <= smp;
                end
                if (smp < min_reg)
                begin
                    min_reg <= smp;
                end
            end
            if (cmd.hist_update)
            begin
                hsum_reg          <= hsum_reg - HSUM_W'(hist_reg[ptr_reg]) + HSUM_W'(mean_reg);
                hist_reg[ptr_reg] <= mean_reg;
                ptr_reg           <= ptr_next;
            end
            if (cmd.result_load)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
                max_reg   <= '0;
                min_reg   <= '1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mean_load)
        begin
            mean_reg <= MEAN_W'(div_quotient);
        end
        if (cmd.mov_load)
        begin
            mov_reg <= AVG_POW2 ? MEAN_W'(hsum_shift) : MEAN_W'(div_quotient);
        end
        if (cmd.mul_lo)
        begin
            plo_reg <= gain_reg * mov_reg[LO_W-1:0];
        end
        if (cmd.mul_hi)
        begin
            phi_reg <= gain_reg * mov_reg[MEAN_W-1:LO_W];
        end
        if (cmd.prod_sum)
        begin
            scaled_reg <= prod[PROD_W-1:GAIN_FRAC];
        end
        if (cmd.result_load)
        begin
            res_mean_reg  <= MEAN_OUT_W'(mean_reg);
            res_max_reg   <= SAMPLE_W'(max_reg);
            res_min_reg   <= SAMPLE_W'(min_reg);
            res_mov_reg   <= MEAN_OUT_W'(mov_reg);
            res_level_reg <= level_sat;
        end
    end

    assign block_mean     = res_mean_reg;
    assign block_max      = res_max_reg;
    assign block_min      = res_min_reg;
    assign moving_average = res_mov_reg;
    assign level_db       = res_level_reg;

endmodule

`default_nettype wire

// ----- src/balm_ctrl.sv -----
`default_nettype none

module balm_ctrl
    import balm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  balm_stat_t stat,
    output balm_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MEAN_START,
        S_MEAN_WAIT,
        S_HIST,
        S_AVG_START,
        S_AVG_WAIT,
        S_MUL_LO,
        S_MUL_HI,
        S_PSUM,
        S_LEVEL
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   load_ok;

    // The result register frees once its transaction completes.
    assign load_ok = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready        = 1'b1;
                cmd.sample_take = in_valid;
                if (in_valid && stat.block_close)
                begin
                    state_next = S_MEAN_START;
                end
            end
            S_MEAN_START:
            begin
                cmd.mean_start = 1'b1;
                state_next     = S_MEAN_WAIT;
            end
            S_MEAN_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    cmd.mean_load = 1'b1;
                    state_next    = S_HIST;
                end
            end
            S_HIST:
            begin
                cmd.hist_update = 1'b1;
                state_next      = S_AVG_START;
            end
            S_AVG_START:
            begin
                if (stat.avg_shift)
                begin
                    cmd.mov_load = 1'b1;
                    state_next   = S_MUL_LO;
                end
                else
                begin
                    cmd.avg_start = 1'b1;
                    state_next    = S_AVG_WAIT;
                end
            end
            S_AVG_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    cmd.mov_load = 1'b1;
                    state_next   = S_MUL_LO;
                end
            end
            S_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_PSUM;
            end
            S_PSUM:
            begin
                cmd.prod_sum = 1'b1;
                state_next   = S_LEVEL;
            end
            S_LEVEL:
            begin
                if (load_ok)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.result_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- src/block_average_level_meter.sv -----
`default_nettype none

// Block average level meter. Samples arrive as transactions on the sample channel and are
// taken one per cycle while a block fills; the sample that completes a block (length set by
// the block_length register) is followed by a closing pass, during which no sample is taken.
// That pass runs the bit-serial divider for the block mean, which produces one quotient bit
// per cycle, followed by the moving average, a two-step gain multiply and the level
// saturation. The moving average is a shift when AVG_DEPTH is a power of two; otherwise it
// takes a second pass through the divider. Each closed block gives one result transaction
// holding its mean, max, min, moving average and level in 1/256 dB; the result waits in an
// output register, so the next block fills while it is unread, and a later block close
// holds until that result has been taken. Configuration writes are always accepted and take
// effect on the next cycle.
module block_average_level_meter
    import balm_pkg::*;
#(
    parameter int AVG_DEPTH   = AVG_DEPTH_DEFAULT,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
    parameter int MAX_BLOCK   = MAX_BLOCK_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    balm_sample_if.sink   samples,
    balm_result_if.source results,
    balm_cfg_if.sink      cfg
);

    `include "block_average_level_meter_assert.svh"

    balm_cmd_t  cmd;
    balm_stat_t stat;

    assign cfg.ready = 1'b1;

    balm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    balm_datapath #(
        .AVG_DEPTH   (AVG_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_BLOCK   (MAX_BLOCK)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .sample         (samples.sample),
        .cfg_write      (cfg.valid),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .block_mean     (results.block_mean),
        .block_max      (results.block_max),
        .block_min      (results.block_min),
        .moving_average (results.moving_average),
        .level_db       (results.level_db)
    );

    `BALM_ASSERT_SAME(a_busy_no_sample, stat.div_busy, !samples.ready, "sample while dividing")
    `BALM_ASSERT_NEXT(a_load_shows, cmd.result_load, results.valid, "loaded result not shown")
    `BALM_ASSERT_NEXT(a_start_busy, cmd.mean_start || cmd.avg_start, stat.div_busy, "divider idle")
    `BALM_ASSERT_ALWAYS(a_cmd_single, $onehot0(cmd), "more than one command in a cycle")

endmodule

`default_nettype wire
